// ----- rtl/sha_pkg.sv -----
package sha_pkg;

    typedef struct packed {
        logic [31:0] message_word;
        logic [2:0]  valid_bytes;
        logic        end_of_message;
    } t_in;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out;

    // Control from the sequencer to the compression core
    typedef struct packed {
        logic        push;   // shift one word into the block buffer
        logic [31:0] word;
        logic        seal;   // this push completes the block: compress it
        logic        init;   // reload the initial hash values
    } t_core_ctl;

    typedef logic [7:0][31:0] t_hash;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DATA,
        S_MARK,
        S_ZERO,
        S_LENHI,
        S_LENLO,
        S_COMP,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        C_IDLE,
        C_ROUND,
        C_FOLD
    } t_core_state;

    localparam logic [3:0]  LEN_SLOT   = 4'd14;
    localparam logic [3:0]  LAST_SLOT  = 4'd15;
    localparam logic [2:0]  FULL_WORD  = 3'd4;
    localparam logic [2:0]  LAST_INDEX = 3'd7;
    localparam logic [5:0]  LAST_ROUND = 6'd63;
    localparam logic [31:0] PAD_WORD   = 32'h8000_0000;

    localparam t_hash INIT_HASH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_s0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_s0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_s1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

// ----- rtl/sha_core.sv -----
module sha_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sha_pkg::t_core_ctl i_ctl,
    output logic               o_busy,
    output sha_pkg::t_hash     o_hash
);
    import sha_pkg::*;

    t_core_state r_state, n_state;
    logic [5:0]  r_round, n_round;
    t_hash       r_h, n_h;
    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [31:0] w_new, t1, t2;
    logic [31:0] ch, maj;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            C_IDLE:  if (i_ctl.push && i_ctl.seal) n_state = C_ROUND;
            C_ROUND: if (r_round == LAST_ROUND) n_state = C_FOLD;
            C_FOLD:  n_state = C_IDLE;
            default: n_state = C_IDLE;
        endcase
    end

    // Round datapath: one SHA-256 round and one schedule step per cycle
    always_comb begin
        ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        maj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1    = r_v[7] + big_s1(r_v[4]) + ch + ROUND_K[r_round] + r_w[0];
        t2    = big_s0(r_v[0]) + maj;
        w_new = r_w[0] + small_s0(r_w[1]) + r_w[9] + small_s1(r_w[14]);
    end

    always_comb begin
        n_round = r_round;
        n_h     = r_h;
        case (r_state)
            C_IDLE: begin
                n_round = '0;
                if (i_ctl.init) n_h = INIT_HASH;
            end
            C_ROUND: n_round = r_round + 6'd1;
            C_FOLD: begin
                for (int i = 0; i < 8; i++) n_h[i] = r_h[i] + r_v[i];
            end
            default: n_round = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_round <= '0;
            r_h     <= INIT_HASH;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
            r_h     <= n_h;
        end
    end

    // Block buffer and working variables
    always_ff @(posedge i_clk) begin
        if (r_state == C_IDLE && i_ctl.push) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= i_ctl.word;
            if (i_ctl.seal) begin
                for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
            end
        end else if (r_state == C_ROUND) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_new;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    assign o_busy = (r_state != C_IDLE);
    assign o_hash = r_h;

endmodule

// ----- rtl/sha256_message_hasher_unit.sv -----
// SHA-256 message hasher.
// Input channel: present a word on i_in with start high; the word is taken at
// the rising edge where start is high and busy is low. Words are big-endian,
// first byte in bits 31..24; valid_bytes (0..4, larger values count as 4) matters
// only on the word flagged end_of_message, which may be partial or empty.
// Result channel: o_res_valid marks each digest word for exactly one cycle;
// eight words follow back to back, word_index 0 first, last_word on index 7.
// The receiver cannot stall; each word is gone after its cycle.
// Flow: a non-final word that does not fill the 16-word block is taken with
// busy staying low. The word that fills a block holds busy for 64 rounds of
// the shared round unit, one per cycle, then a step to fold the working
// variables into the chaining value, and a step to hand control back to the
// sequencer.
// A final word costs padding pushes (one per cycle up to the length slot, paused
// by compression), one or two compressions, then the eight digest words, after
// which the chaining value, fill and byte count return to their initial values.
// Reset (synchronous, active low) restores the initial hash values and clears
// the fill and byte counters; the block buffer is not cleared.
module sha256_message_hasher_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  sha_pkg::t_in  i_in,
    output logic          o_res_valid,
    output sha_pkg::t_out o_res
);
    import sha_pkg::*;

    t_state      r_state, n_state;
    t_state      r_ret, n_ret;
    logic [3:0]  r_fill, n_fill;
    logic [60:0] r_bytes, n_bytes;
    logic [2:0]  r_idx, n_idx;
    logic [31:0] r_word, n_word;
    logic [2:0]  r_nb, n_nb;

    t_core_ctl   core_ctl;
    logic        core_busy;
    t_hash       core_hash;
    t_state      follow;
    logic        accept;
    logic [2:0]  nb_sat;
    logic [4:0]  sh;
    logic [31:0] tail_word;

    assign accept = start && (r_state == S_IDLE);
    assign nb_sat = (i_in.valid_bytes > FULL_WORD) ? FULL_WORD : i_in.valid_bytes;

    // Final partial word: keep the valid high bytes, drop in the pad byte after them
    assign sh        = {r_nb[1:0], 3'b000};
    assign tail_word = (r_word & ~(32'hffff_ffff >> sh)) | (PAD_WORD >> sh);

    // Next state: any push that completes a block detours through compression
    always_comb begin
        follow = r_state;
        case (r_state)
            S_IDLE:  follow = (accept && i_in.end_of_message) ? S_DATA : S_IDLE;
            S_DATA:  follow = (r_nb == FULL_WORD) ? S_MARK : S_ZERO;
            S_MARK:  follow = S_ZERO;
            S_ZERO:  follow = (r_fill == LEN_SLOT) ? S_LENHI : S_ZERO;
            S_LENHI: follow = S_LENLO;
            S_LENLO: follow = S_OUT;
            S_COMP:  follow = core_busy ? S_COMP : r_ret;
            S_OUT:   follow = (r_idx == LAST_INDEX) ? S_IDLE : S_OUT;
            default: follow = S_IDLE;
        endcase
        n_ret = r_ret;
        if (core_ctl.push && core_ctl.seal) begin
            n_state = S_COMP;
            n_ret   = follow;
        end else begin
            n_state = follow;
        end
    end

    // Outputs and datapath
    always_comb begin
        core_ctl = '0;
        n_fill   = r_fill;
        n_bytes  = r_bytes;
        n_idx    = r_idx;
        n_word   = r_word;
        n_nb     = r_nb;
        case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (accept) begin
                    if (i_in.end_of_message) begin
                        n_word  = i_in.message_word;
                        n_nb    = nb_sat;
                        n_bytes = r_bytes + 61'(nb_sat);
                    end else begin
                        core_ctl.push = 1'b1;
                        core_ctl.word = i_in.message_word;
                        n_bytes       = r_bytes + 61'(FULL_WORD);
                    end
                end
            end
            S_DATA: begin
                core_ctl.push = 1'b1;
                core_ctl.word = (r_nb == FULL_WORD) ? r_word : tail_word;
            end
            S_MARK: begin
                core_ctl.push = 1'b1;
                core_ctl.word = PAD_WORD;
            end
            S_ZERO: begin
                core_ctl.push = (r_fill != LEN_SLOT);
                core_ctl.word = '0;
            end
            S_LENHI: begin
                core_ctl.push = 1'b1;
                core_ctl.word = r_bytes[60:29];
            end
            S_LENLO: begin
                core_ctl.push = 1'b1;
                core_ctl.word = {r_bytes[28:0], 3'b000};
            end
            S_COMP: core_ctl = '0;
            S_OUT: begin
                n_idx = r_idx + 3'd1;
                if (r_idx == LAST_INDEX) begin
                    core_ctl.init = 1'b1;
                    n_bytes       = '0;
                end
            end
            default: core_ctl = '0;
        endcase
        core_ctl.seal = core_ctl.push && (r_fill == LAST_SLOT);
        if (core_ctl.push) n_fill = r_fill + 4'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_fill  <= '0;
            r_bytes <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_fill  <= n_fill;
            r_bytes <= n_bytes;
            r_idx   <= n_idx;
        end
    end

    // Hold the final word until padding has consumed it
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_nb   <= n_nb;
    end

    sha_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (core_ctl),
        .o_busy  (core_busy),
        .o_hash  (core_hash)
    );

    assign busy                = (r_state != S_IDLE);
    assign o_res_valid         = (r_state == S_OUT);
    assign o_res.digest_word   = core_hash[r_idx];
    assign o_res.word_index    = r_idx;
    assign o_res.last_word     = (r_idx == LAST_INDEX);

endmodule

// ----- rtl/sha_chk.sv -----
module sha_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input sha_pkg::t_in  i_in,
    input logic          o_res_valid,
    input sha_pkg::t_out o_res
);
    import sha_pkg::*;

    // Digest words come out while the block is busy
    a_res_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> busy)
        else $error("digest word outside busy window");

    // Digest words run back to back in index order
    a_res_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.word_index != LAST_INDEX) |=>
            (o_res_valid && o_res.word_index == $past(o_res.word_index) + 3'd1))
        else $error("digest word sequence broken");

    // last_word flags exactly the eighth word
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res.last_word == (o_res.word_index == LAST_INDEX)))
        else $error("last_word mismatch");

    // A final word always starts the padding sequence
    a_eom_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_in.end_of_message) |=> busy)
        else $error("final word did not start finishing");

endmodule

bind sha256_message_hasher_unit sha_chk u_sha_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_in        (i_in),
    .o_res_valid (o_res_valid),
    .o_res       (o_res)
);

// ----- bench/tb_sha256_message_hasher_unit.sv -----
`timescale 1ns / 100ps

module tb_sha256_message_hasher_unit;

    import sha_pkg::*;

    // Give up well past the slowest legal run: ~400 words, each either a full
    // compression or a final word with two compressions plus eight outputs,
    // plus the sender's longest gaps.
    localparam int CYCLE_LIMIT  = 500000;
    localparam int RAND_WORDS   = 350;
    localparam int CALM_FROM    = 280;   // no idling once this many random words are in
    localparam int SETTLE_CYC   = 40;

    // Round constants and initial hash value, held here for the digest predictor
    localparam logic [0:63][31:0] K_TAB = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [0:7][31:0] H_INIT = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] PAD_BIT = 32'h8000_0000;

    // One row of the directed script: the word to send and, where the digest
    // is a well-known value, that digest (word 0 in the top bits).
    typedef struct packed {
        t_in          word;
        logic         known;
        logic [255:0] digest;
    } t_row;

    localparam int N_ROWS = 11;

    localparam t_row DIR_ROWS [N_ROWS] = '{
        // empty message: one empty final word
        '{'{32'h0000_0000, 3'd0, 1'b1}, 1'b1,
          256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855},
        // "abc" with junk in the unused low byte, which must be dropped
        '{'{32'h6162_63a5, 3'd3, 1'b1}, 1'b1,
          256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad},
        // byte count above four saturates to a full word
        '{'{32'hffff_ffff, 3'd7, 1'b1}, 1'b0, 256'h0},
        // full final word of zeros
        '{'{32'h0000_0000, 3'd4, 1'b1}, 1'b0, 256'h0},
        // one and two valid bytes in the tail
        '{'{32'h80ff_ffff, 3'd1, 1'b1}, 1'b0, 256'h0},
        '{'{32'hdead_beef, 3'd2, 1'b1}, 1'b0, 256'h0},
        // non-final words ignore their byte count, then an empty tail
        '{'{32'hffff_ffff, 3'd0, 1'b0}, 1'b0, 256'h0},
        '{'{32'h0000_0000, 3'd5, 1'b0}, 1'b0, 256'h0},
        '{'{32'h1234_5678, 3'd0, 1'b1}, 1'b0, 256'h0},
        // short message ending on a full word
        '{'{32'ha5a5_a5a5, 3'd3, 1'b0}, 1'b0, 256'h0},
        '{'{32'h5a5a_5a5a, 3'd4, 1'b1}, 1'b0, 256'h0}
    };

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start   = 1'b0;
    t_in   i_in    = '0;
    logic  busy;
    logic  o_res_valid;
    t_out  o_res;

    sha256_message_hasher_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (i_in),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    always #10 i_clk = ~i_clk;

    // Predictor state: chaining value, block buffer, fill and byte count
    logic [31:0] chain_h [8];
    logic [31:0] blk_w   [16];
    int unsigned blk_fill;
    logic [60:0] msg_bytes;

    t_out digest_q [$];     // digest words still owed by the block
    t_out next_dw;

    int err_cnt     = 0;
    int words_sent  = 0;
    int rand_words  = 0;
    int msgs_done   = 0;
    int dw_checked  = 0;
    int cyc         = 0;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Run the 64 rounds over the buffered block and fold into the chaining value
    function automatic void sha_compress();
        logic [31:0] sched [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, x, y;
        for (int i = 0; i < 16; i++) sched[i] = blk_w[i];
        for (int i = 16; i < 64; i++) begin
            x = sched[i-15];
            y = sched[i-2];
            sched[i] = sched[i-16] + (ror(x, 7) ^ ror(x, 18) ^ (x >> 3))
                     + sched[i-7] + (ror(y, 17) ^ ror(y, 19) ^ (y >> 10));
        end
        a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
        e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
        for (int i = 0; i < 64; i++) begin
            t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
               + K_TAB[i] + sched[i];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
        chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
    endfunction

    function automatic void buf_push(input logic [31:0] w);
        blk_w[blk_fill] = w;
        blk_fill = (blk_fill + 1) % 16;
        if (blk_fill == 0) sha_compress();
    endfunction

    function automatic void hash_restart();
        for (int i = 0; i < 8; i++) chain_h[i] = H_INIT[i];
        blk_fill  = 0;
        msg_bytes = '0;
    endfunction

    // Absorb one accepted word; on the final word pad, close the message and
    // queue the eight digest words (the typed-in digest where one is given).
    function automatic void absorb_word(input t_in w, input logic known,
                                        input logic [255:0] dig);
        int          nb;
        logic [31:0] keep;
        logic [63:0] bit_len;
        t_out        dw;
        nb = (w.valid_bytes > FULL_WORD || !w.end_of_message) ? 4 : int'(w.valid_bytes);
        msg_bytes = msg_bytes + 61'(nb);
        if (!w.end_of_message) begin
            buf_push(w.message_word);
            return;
        end
        if (nb == 4) begin
            buf_push(w.message_word);
            buf_push(PAD_BIT);
        end else begin
            keep = (nb == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * nb));
            buf_push((w.message_word & keep) | (32'h80 << (24 - 8 * nb)));
        end
        // no room left for the length: zero out this block and start another
        if (blk_fill > 14) begin
            while (blk_fill != 0) buf_push(32'h0);
        end
        while (blk_fill < 14) buf_push(32'h0);
        bit_len = {msg_bytes, 3'b000};
        buf_push(bit_len[63:32]);
        buf_push(bit_len[31:0]);
        for (int i = 0; i < 8; i++) begin
            dw.digest_word = known ? dig[255 - 32 * i -: 32] : chain_h[i];
            dw.word_index  = 3'(i);
            dw.last_word   = (i == 7);
            digest_q = {digest_q, dw};
        end
        hash_restart();
        msgs_done++;
    endfunction

    // Present one word and hold it until the block takes it
    task automatic send_word(input t_in w, input logic known, input logic [255:0] dig);
        start <= 1'b1;
        i_in  <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        absorb_word(w, known, dig);
        words_sent++;
    endtask

    // Drop start for a random stretch of idle clocks, now and then, unless calm
    task automatic maybe_idle(input bit calm);
        if (!calm && $urandom_range(0, 4) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    // Hold the sender until every owed digest word has come out
    task automatic drain_digests();
        start <= 1'b0;
        @(posedge i_clk);
        while (digest_q.size() != 0) @(posedge i_clk);
    endtask

    // One random message of n_words full words plus a final word with a
    // random byte count; non-final words carry a random (ignored) count too.
    task automatic send_message(input int n_words, input bit calm);
        t_in w;
        for (int k = 0; k <= n_words; k++) begin
            maybe_idle(calm);
            w.message_word   = $urandom;
            w.valid_bytes    = 3'($urandom_range(0, 7));
            w.end_of_message = (k == n_words);
            send_word(w, 1'b0, 256'h0);
            rand_words++;
        end
    endtask

    // Check each digest word against the oldest one owed
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid) begin
            if (digest_q.size() == 0) begin
                $display("%0t: unexpected digest word: got %h idx %0d last %b",
                         $time, o_res.digest_word, o_res.word_index, o_res.last_word);
                err_cnt++;
            end else begin
                next_dw = digest_q.pop_front();
                dw_checked++;
                if (o_res.digest_word !== next_dw.digest_word
                        || o_res.word_index !== next_dw.word_index
                        || o_res.last_word !== next_dw.last_word) begin
                    $display("%0t: digest mismatch: expected %h idx %0d last %b, got %h idx %0d last %b",
                             $time, next_dw.digest_word, next_dw.word_index, next_dw.last_word,
                             o_res.digest_word, o_res.word_index, o_res.last_word);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog: abort if the run hangs
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d digest words outstanding",
                     $time, cyc, digest_q.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int len;
        int kind;
        int dir_msgs;
        hash_restart();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed script: empty message, known digests, byte-count corners
        for (int r = 0; r < N_ROWS; r++) begin
            maybe_idle(1'b0);
            send_word(DIR_ROWS[r].word, DIR_ROWS[r].known, DIR_ROWS[r].digest);
        end
        drain_digests();
        dir_msgs = msgs_done;

        // Random messages. Start with lengths around the block boundary, where
        // the tail lands on the length slots or spills into an extra block.
        while (rand_words < RAND_WORDS) begin
            if (msgs_done < dir_msgs + 8) begin
                len = 12 + (msgs_done - dir_msgs);   // walks 12..19 full words
            end else begin
                kind = $urandom_range(0, 3);
                case (kind)
                    0: begin
                        len = $urandom_range(0, 3);
                    end
                    1: begin
                        len = $urandom_range(12, 17);
                    end
                    2: begin
                        len = $urandom_range(28, 33);
                    end
                    default: begin
                        len = $urandom_range(4, 11);
                    end
                endcase
            end
            send_message(len, rand_words >= CALM_FROM);
            if (msgs_done == 20) drain_digests();
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);

        $display("Hashed %0d messages from %0d words; %0d digest words checked.",
                 msgs_done, words_sent, dw_checked);
        $display("Covered empty and partial tails, byte counts 0..7, block-boundary lengths.");
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
